// ===== design/key_cutting_bit_mutator_assert.svh =====
// assertion macros for the key cutting bit mutator
// KCBM_ASSERT checks under reset qualification, KCBM_ASSERT_ALWAYS checks at every edge
`ifndef KEY_CUTTING_BIT_MUTATOR_ASSERT_SVH
`define KEY_CUTTING_BIT_MUTATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define KCBM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define KCBM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KCBM_ASSERT(lbl, clk, rst_n, prop, msg)
`define KCBM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== design/kcbm_pkg.sv =====
`default_nettype none

package kcbm_pkg;

    localparam int HALF_MAX_DEF = 64;
    localparam int KEY_MAX_DEF  = 256;

    localparam int OPC_W     = 3;
    localparam int ROW_W     = 6;
    localparam int COL_W     = 8;
    localparam int CNT_W     = 7;
    localparam int HALF_W    = 7;
    localparam int KBITS_W   = 9;
    localparam int WORD_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int IN_W      = 16;
    localparam int OUT_W     = 16;

    localparam logic [WORD_W-1:0] LCG_MUL = 32'd1664525;
    localparam logic [WORD_W-1:0] LCG_ADD = 32'd1013904223;
    localparam logic [CNT_W-1:0]  ONES_MAX = 7'd127;

    localparam logic              RST_FLIP_BELOW = 1'b1;
    localparam logic [HALF_W-1:0] RST_HALF_SIZE  = 7'd32;
    localparam logic [KBITS_W-1:0] RST_KEY_BITS  = 9'd20;
    localparam logic [WORD_W-1:0] RST_INIT_THR   = 32'h8000_0000;
    localparam logic [WORD_W-1:0] RST_SEED       = 32'd42;
    localparam logic [WORD_W-1:0] RST_RANDOM     = 32'd42;

    typedef enum logic [OPC_W-1:0] {
        OP_RESEED = 3'd0,
        OP_CLEAR  = 3'd1,
        OP_LOAD   = 3'd2,
        OP_INIT   = 3'd3,
        OP_MUTATE = 3'd4
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FLIP_BELOW = 3'd0,
        CFG_HALF_SIZE  = 3'd1,
        CFG_KEY_BITS   = 3'd2,
        CFG_INIT_THR   = 3'd3,
        CFG_SEED       = 3'd4
    } t_cfg_idx;

    // request payload, lowest bits last
    typedef struct packed {
        logic             pad;
        logic             bit_in;
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] row;
    } t_in_data;

    typedef struct packed {
        logic [COL_W-1:0] column_out;
        logic [ROW_W-1:0] row_out;
        logic             flipped;
        logic             bit_out;
    } t_out_data;

endpackage

`default_nettype wire

// ===== design/kcbm_ram.sv =====
`default_nettype none

module kcbm_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // read returns the old word on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/key_cutting_bit_mutator.sv =====
// result: request and RAM read registered into the second stage, the compare into the output
// throughput: one request per cycle while the output is not stalled; back-to-back load
//   and mutate on one column or bit are served by forwarding around the count and parent RAMs
// reset: i_rst_n synchronous active low; config returns to defaults, generator to 42,
//   column counts read as zero through per-column valid bits; parent bits keep no reset
`default_nettype none

`include "key_cutting_bit_mutator_assert.svh"

module key_cutting_bit_mutator #(
    parameter int HALF_MAX = kcbm_pkg::HALF_MAX_DEF,
    parameter int KEY_MAX  = kcbm_pkg::KEY_MAX_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    // row[5:0], column[13:6], bit_in[14], zero pad[15]
    input  wire logic [kcbm_pkg::IN_W-1:0]      i_s_tdata,
    // opcode[2:0]
    input  wire logic [kcbm_pkg::OPC_W-1:0]     i_s_tuser,
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    // bit_out[0], flipped[1], row_out[7:2], column_out[15:8]
    output logic      [kcbm_pkg::OUT_W-1:0]     o_m_tdata,
    input  wire logic                           i_cfg_we,
    input  wire logic [kcbm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [kcbm_pkg::WORD_W-1:0]    i_cfg_data
);

    localparam int PAR_DEPTH = HALF_MAX * KEY_MAX;
    localparam int PAR_AW    = (PAR_DEPTH > 1) ? $clog2(PAR_DEPTH) : 1;
    localparam int CNT_AW    = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;

    localparam int CNT_W  = kcbm_pkg::CNT_W;
    localparam int WORD_W = kcbm_pkg::WORD_W;
    localparam int HALF_W = kcbm_pkg::HALF_W;

    // config registers
    logic                          r_flip_below;
    logic [HALF_W-1:0]             r_half;
    logic [kcbm_pkg::KBITS_W-1:0]  r_key_bits;
    logic [WORD_W-1:0]             r_init_thr;
    logic [WORD_W-1:0]             r_seed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flip_below <= kcbm_pkg::RST_FLIP_BELOW;
            r_half       <= kcbm_pkg::RST_HALF_SIZE;
            r_key_bits   <= kcbm_pkg::RST_KEY_BITS;
            r_init_thr   <= kcbm_pkg::RST_INIT_THR;
            r_seed       <= kcbm_pkg::RST_SEED;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                kcbm_pkg::CFG_FLIP_BELOW: r_flip_below <= i_cfg_data[0];
                kcbm_pkg::CFG_HALF_SIZE:  r_half       <= i_cfg_data[HALF_W-1:0];
                kcbm_pkg::CFG_KEY_BITS:   r_key_bits   <= i_cfg_data[kcbm_pkg::KBITS_W-1:0];
                kcbm_pkg::CFG_INIT_THR:   r_init_thr   <= i_cfg_data;
                kcbm_pkg::CFG_SEED:       r_seed       <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // request decode
    kcbm_pkg::t_in_data s0_req;
    logic [kcbm_pkg::OPC_W-1:0] s0_op;
    logic                s_fire;
    logic                s0_in_store;
    logic                s0_ld_ok;
    logic [PAR_AW-1:0]   s0_par_addr;
    logic [CNT_AW-1:0]   s0_col_idx;

    assign s0_req      = kcbm_pkg::t_in_data'(i_s_tdata);
    assign s0_op       = i_s_tuser;
    assign s_fire      = i_s_tvalid && o_s_tready;
    assign s0_in_store = (32'(s0_req.row) < 32'(HALF_MAX))
                         && (32'(s0_req.column) < 32'(KEY_MAX));
    assign s0_ld_ok    = s0_in_store && ({1'b0, s0_req.row} < r_half)
                         && ({1'b0, s0_req.column} < r_key_bits);
    assign s0_col_idx  = CNT_AW'(s0_req.column);
    assign s0_par_addr = PAR_AW'(PAR_AW'(s0_req.row) * PAR_AW'(KEY_MAX))
                         + PAR_AW'(s0_req.column);

    // random generator: an accepted reseed loads the seed, an accepted init or mutate advances it
    logic [WORD_W-1:0] r_rand;
    logic [WORD_W-1:0] n_rand;

    assign n_rand = WORD_W'(r_rand * kcbm_pkg::LCG_MUL) + kcbm_pkg::LCG_ADD;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rand <= kcbm_pkg::RST_RANDOM;
        end else if (s_fire) begin
            if (s0_op == kcbm_pkg::OP_RESEED) begin
                r_rand <= r_seed;
            end else if (s0_op == kcbm_pkg::OP_INIT || s0_op == kcbm_pkg::OP_MUTATE) begin
                r_rand <= n_rand;
            end
        end
    end

    // second stage, RAM data arrives here
    logic                        r_s1_valid;
    logic [kcbm_pkg::OPC_W-1:0]  r_s1_op;
    logic [kcbm_pkg::ROW_W-1:0]  r_s1_row;
    logic [kcbm_pkg::COL_W-1:0]  r_s1_col;
    logic                        r_s1_bit;
    logic                        r_s1_in_store;
    logic                        r_s1_ld_ok;
    logic                        r_s1_cnt_vld;
    logic [PAR_AW-1:0]           r_s1_par_addr;
    logic [CNT_AW-1:0]           r_s1_col_idx;

    logic                        r_fwd_cnt_hit;
    logic [CNT_W-1:0]            r_fwd_cnt;
    logic                        r_fwd_par_hit;
    logic                        r_fwd_par;

    logic [KEY_MAX-1:0]          r_cnt_vld;

    logic [CNT_W-1:0]            cnt_rdata;
    logic [0:0]                  par_rdata;
    logic                        cnt_we;
    logic [CNT_W-1:0]            cnt_wdata;
    logic                        par_we;
    logic [CNT_W-1:0]            cnt_eff;
    logic                        par_eff;
    logic                        s1_has_res;
    logic                        s1_done;
    logic                        n_fwd_cnt_hit;
    logic                        n_fwd_par_hit;

    kcbm_ram #(
        .WIDTH (CNT_W),
        .DEPTH (KEY_MAX)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (r_s1_col_idx),
        .i_wdata (cnt_wdata),
        .i_re    (s_fire),
        .i_raddr (s0_col_idx),
        .o_rdata (cnt_rdata)
    );

    kcbm_ram #(
        .WIDTH (1),
        .DEPTH (PAR_DEPTH)
    ) u_par_ram (
        .i_clk   (i_clk),
        .i_we    (par_we),
        .i_waddr (r_s1_par_addr),
        .i_wdata (r_s1_bit),
        .i_re    (s_fire),
        .i_raddr (s0_par_addr),
        .o_rdata (par_rdata)
    );

    // forwarded data wins over the RAM word written in the same cycle it was read
    always_comb begin
        if (!r_s1_in_store) begin
            cnt_eff = '0;
            par_eff = 1'b0;
        end else begin
            cnt_eff = r_fwd_cnt_hit ? r_fwd_cnt : (r_s1_cnt_vld ? cnt_rdata : '0);
            par_eff = r_fwd_par_hit ? r_fwd_par : par_rdata[0];
        end
    end

    assign par_we    = r_s1_valid && (r_s1_op == kcbm_pkg::OP_LOAD) && r_s1_ld_ok;
    assign cnt_we    = par_we && r_s1_bit;
    assign cnt_wdata = (cnt_eff == kcbm_pkg::ONES_MAX) ? cnt_eff : cnt_eff + CNT_W'(1);

    assign s1_has_res = (r_s1_op == kcbm_pkg::OP_INIT) || (r_s1_op == kcbm_pkg::OP_MUTATE);
    assign s1_done    = r_s1_valid && (!s1_has_res || !o_m_tvalid || i_m_tready);
    assign o_s_tready = !r_s1_valid || s1_done;

    assign n_fwd_cnt_hit = cnt_we && s0_in_store && (s0_col_idx == r_s1_col_idx);
    assign n_fwd_par_hit = par_we && s0_in_store && (s0_par_addr == r_s1_par_addr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid    <= 1'b0;
            r_fwd_cnt_hit <= 1'b0;
            r_fwd_par_hit <= 1'b0;
        end else if (s_fire) begin
            r_s1_valid    <= 1'b1;
            r_fwd_cnt_hit <= n_fwd_cnt_hit;
            r_fwd_par_hit <= n_fwd_par_hit;
        end else if (s1_done) begin
            r_s1_valid    <= 1'b0;
            r_fwd_cnt_hit <= 1'b0;
            r_fwd_par_hit <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_s1_op       <= s0_op;
            r_s1_row      <= s0_req.row;
            r_s1_col      <= s0_req.column;
            r_s1_bit      <= s0_req.bit_in;
            r_s1_in_store <= s0_in_store;
            r_s1_ld_ok    <= s0_ld_ok;
            r_s1_cnt_vld  <= s0_in_store && r_cnt_vld[s0_col_idx];
            r_s1_par_addr <= s0_par_addr;
            r_s1_col_idx  <= s0_col_idx;
            r_fwd_cnt     <= cnt_wdata;
            r_fwd_par     <= r_s1_bit;
        end
    end

    // a clear in the first stage overrides a count write still finishing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_vld <= '0;
        end else if (s_fire && s0_op == kcbm_pkg::OP_CLEAR) begin
            r_cnt_vld <= '0;
        end else if (cnt_we) begin
            r_cnt_vld[r_s1_col_idx] <= 1'b1;
        end
    end

    // exact compare of r/2^32 against 1 - ones/h: r*h against (h - ones)*2^32
    logic [HALF_W-1:0]        h_eff;
    logic signed [HALF_W:0]   diff;
    logic [WORD_W+HALF_W-1:0] lhs;
    logic signed [WORD_W+HALF_W+1:0] lhs_s;
    logic signed [WORD_W+HALF_W+1:0] rhs_s;
    logic                     flip;
    logic                     init_bit;
    kcbm_pkg::t_out_data      n_out;

    assign h_eff = (r_half == '0) ? HALF_W'(1) : r_half;
    assign diff  = $signed({1'b0, h_eff}) - $signed({1'b0, cnt_eff});
    assign lhs   = {{HALF_W{1'b0}}, r_rand} * {{WORD_W{1'b0}}, h_eff};
    assign lhs_s = $signed({2'b00, lhs});
    assign rhs_s = $signed({diff[HALF_W], diff, {WORD_W{1'b0}}});
    assign flip  = r_flip_below ? (lhs_s < rhs_s) : (lhs_s > rhs_s);
    assign init_bit = r_rand < r_init_thr;

    always_comb begin
        n_out.row_out    = r_s1_row;
        n_out.column_out = r_s1_col;
        if (r_s1_op == kcbm_pkg::OP_MUTATE) begin
            n_out.bit_out = par_eff ^ flip;
            n_out.flipped = flip;
        end else begin
            n_out.bit_out = init_bit;
            n_out.flipped = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_m_tvalid <= 1'b0;
        end else if (s1_done && s1_has_res) begin
            o_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            o_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_done && s1_has_res) begin
            o_m_tdata <= n_out;
        end
    end

    `KCBM_ASSERT(a_result_lands, i_clk, i_rst_n,
        (s1_done && s1_has_res) |=> o_m_tvalid, "finished result not presented")
    `KCBM_ASSERT(a_fwd_cnt_in_flight, i_clk, i_rst_n,
        r_fwd_cnt_hit |-> r_s1_valid, "count forward without request in flight")
    `KCBM_ASSERT(a_fwd_par_in_flight, i_clk, i_rst_n,
        r_fwd_par_hit |-> r_s1_valid, "parent forward without request in flight")
    `KCBM_ASSERT(a_clear_empties, i_clk, i_rst_n,
        (s_fire && s0_op == kcbm_pkg::OP_CLEAR) |=> (r_cnt_vld == '0),
        "clear left a valid count")
    `KCBM_ASSERT(a_count_nonzero, i_clk, i_rst_n,
        cnt_we |-> (cnt_wdata != '0), "count write of zero")

endmodule

`default_nettype wire
